// ===== rtl/sqdp_pkg.sv =====
// ----------------------------------------------------------------------------
// sqdp_pkg
// Shared widths, codes, types and helpers of the quadratic delay profile unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sqdp_pkg;

	// field widths
	localparam int STEPS_W = 16;
	localparam int POS_W   = 21;
	localparam int INC_W   = 16;
	localparam int COEF_W  = 16;
	localparam int SCALE_W = 12;
	localparam int DELAY_W = 16;

	// shift-add unit: product register holds (a*x*x + b) * scale exactly
	localparam int PROD_W  = 69;
	localparam int MPLR_W  = 21;
	localparam int FRAC_W  = 40;
	localparam int B_SHIFT = 32;

	// stream and configuration widths
	localparam int S_DATA_W   = 8;
	localparam int M_DATA_W   = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 21;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TOTAL_STEPS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_X_START     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_X_END       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_X_INCREMENT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_A      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_B    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_DELAY_SCALE = 3'd6;

	// configuration reset values
	localparam logic [STEPS_W-1:0]       TOTAL_STEPS_RST = 16'd267;
	localparam logic signed [POS_W-1:0]  X_START_RST     = -21'sd98304;
	localparam logic signed [POS_W-1:0]  X_END_RST       = 21'sd98304;
	localparam logic [INC_W-1:0]         X_INCREMENT_RST = 16'd737;
	localparam logic [COEF_W-1:0]        COEF_A_RST      = 16'd512;
	localparam logic [COEF_W-1:0]        OFFSET_B_RST    = 16'd64;
	localparam logic [SCALE_W-1:0]       DELAY_SCALE_RST = 12'd500;

	// pulse phase codes
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_HIGH = 2'd1;
	localparam logic [1:0] PH_LOW  = 2'd2;

	// input kinds
	localparam logic ACT_START = 1'b0;
	localparam logic ACT_TICK  = 1'b1;

	typedef struct packed {
		logic              load;
		logic [PROD_W-1:0] mcand;
		logic [MPLR_W-1:0] mplier;
		logic [PROD_W-1:0] acc_init;
	} mul_cmd_t;

	typedef struct packed {
		logic              busy;
		logic [PROD_W-1:0] prod;
	} mul_sts_t;

	// a half period lasts at least one tick
	function automatic logic [DELAY_W-1:0] half_len(input logic [DELAY_W-1:0] d);
		return (d == '0) ? DELAY_W'(1) : d;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/sqdp_mul.sv =====
// ----------------------------------------------------------------------------
// sqdp_mul
// Shift-add multiply-accumulate unit, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sqdp_mul
	import sqdp_pkg::*;
(
	input  wire           clk,
	input  wire           arst_n,
	input  wire mul_cmd_t cmd,
	output mul_sts_t      sts
);

	logic              busy_q;
	logic [PROD_W-1:0] acc_q;
	logic [PROD_W-1:0] mcand_q;
	logic [MPLR_W-1:0] mplier_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (cmd.load) begin
			busy_q <= |cmd.mplier;
		end else if (busy_q) begin
			busy_q <= |mplier_q[MPLR_W-1:1];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			acc_q    <= cmd.acc_init;
			mcand_q  <= cmd.mcand;
			mplier_q <= cmd.mplier;
		end else if (busy_q) begin
			if (mplier_q[0]) begin
				acc_q <= acc_q + mcand_q;
			end
			mcand_q  <= mcand_q << 1;
			mplier_q <= mplier_q >> 1;
		end
	end

	assign sts.busy = busy_q;
	assign sts.prod = acc_q;

endmodule

`default_nettype wire

// ===== rtl/stepper_quadratic_delay_profile_unit.sv =====
// ----------------------------------------------------------------------------
// stepper_quadratic_delay_profile_unit
// Step pulse generator whose half period follows floor((a*x*x + b) * scale).
// ----------------------------------------------------------------------------
//
//  channel  | direction | fields
//  ---------+-----------+--------------------------------------------------
//  s_*      | in        | tuser: action (0 start, 1 tick); tdata: direction
//  m_*      | out       | tdata: pulse, direction, busy, delay; tlast: done
//  cfg_*    | in        | cfg_index selects a register, cfg_data its value
//
//  Every transaction on s_* gives one transaction on m_*. Items that do not
//  begin a step are updated, then loaded into the output register. Items that
//  begin a step run three passes of the shared shift-add unit (x*x, times a
//  plus b, times scale), one multiplier bit per cycle and stopping when the
//  remaining multiplier bits are zero, before the output register load.
//  s_tready is high only in the idle state; a pending output transaction
//  does not block acceptance until the next result is ready. Reset clears
//  state and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module stepper_quadratic_delay_profile_unit
	import sqdp_pkg::*;
(
	input  wire                   clk,
	input  wire                   arst_n,
	// input stream
	input  wire                   s_tvalid,
	output logic                  s_tready,
	input  wire  [S_DATA_W-1:0]   s_tdata,   // [0] direction, [7:1] zero
	input  wire  [0:0]            s_tuser,   // [0] action
	// output stream
	output logic                  m_tvalid,
	input  wire                   m_tready,
	output logic [M_DATA_W-1:0]   m_tdata,   // [0] pulse_level, [1] direction_level,
	                                         // [2] busy_res, [18:3] step_delay_us,
	                                         // [23:19] zero
	output logic                  m_tlast,   // move_done
	// configuration writes
	input  wire                   cfg_valid,
	output logic                  cfg_ready,
	input  wire  [CFG_IDX_W-1:0]  cfg_index,
	input  wire  [CFG_DATA_W-1:0] cfg_data
);

	// sequencer states
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SQ_LD  = 3'd1;
	localparam logic [2:0] ST_SQ_RUN = 3'd2;
	localparam logic [2:0] ST_A_LD   = 3'd3;
	localparam logic [2:0] ST_A_RUN  = 3'd4;
	localparam logic [2:0] ST_S_LD   = 3'd5;
	localparam logic [2:0] ST_S_RUN  = 3'd6;
	localparam logic [2:0] ST_EMIT   = 3'd7;

	localparam logic signed [POS_W:0] POS_MAX = (POS_W+1)'((2 ** (POS_W - 1)) - 1);

	// configuration registers
	logic [STEPS_W-1:0]      total_steps_q;
	logic signed [POS_W-1:0] x_start_q;
	logic signed [POS_W-1:0] x_end_q;
	logic [INC_W-1:0]        x_inc_q;
	logic [COEF_W-1:0]       coef_a_q;
	logic [COEF_W-1:0]       offset_b_q;
	logic [SCALE_W-1:0]      scale_q;

	// move state
	logic [2:0]              state_q;
	logic                    dir_q;
	logic [STEPS_W-1:0]      step_q;
	logic signed [POS_W-1:0] pos_q;
	logic [DELAY_W-1:0]      half_delay_q;
	logic [DELAY_W-1:0]      delay_left_q;
	logic [1:0]              phase_q;
	logic                    done_q;

	// output register
	logic                    m_tvalid_q;
	logic [M_DATA_W-1:0]     m_tdata_q;
	logic                    m_tlast_q;

	mul_cmd_t mul_cmd;
	mul_sts_t mul_sts;

	logic                    accept;
	logic                    in_action;
	logic                    in_dir;
	logic                    is_idle;
	logic                    empty_move;
	logic [DELAY_W-1:0]      dl_dec;
	logic [STEPS_W-1:0]      step_inc;
	logic signed [POS_W:0]   pos_next;
	logic signed [POS_W-1:0] pos_sat;
	logic [POS_W-1:0]        pos_abs;
	logic [DELAY_W-1:0]      delay_sat;
	logic                    emit_go;
	logic                    busy_now;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign in_action = s_tuser[0];
	assign in_dir    = s_tdata[0];

	// phase code 3 is never produced but counts as idle
	assign is_idle    = (phase_q != PH_HIGH) && (phase_q != PH_LOW);
	assign empty_move = (total_steps_q == '0) || (x_start_q >= x_end_q);
	assign dl_dec     = delay_left_q - DELAY_W'(1);
	assign step_inc   = step_q + STEPS_W'(1);
	assign pos_next   = (POS_W+1)'(pos_q) + $signed({{(POS_W+1-INC_W){1'b0}}, x_inc_q});
	assign pos_sat    = (pos_next > POS_MAX) ? POS_MAX[POS_W-1:0] : pos_next[POS_W-1:0];
	assign pos_abs    = pos_q[POS_W-1] ? POS_W'(-pos_q) : POS_W'(pos_q);

	// drop the Q.40 fraction, saturate at the delay width
	assign delay_sat = (|mul_sts.prod[PROD_W-1:FRAC_W+DELAY_W]) ? '1
		: mul_sts.prod[FRAC_W+DELAY_W-1:FRAC_W];

	assign emit_go  = (state_q == ST_EMIT) && (!m_tvalid_q || m_tready);
	assign busy_now = (phase_q == PH_HIGH) || (phase_q == PH_LOW);

	// operand selection for the shared multiplier
	always_comb begin
		mul_cmd.load     = 1'b0;
		mul_cmd.mcand    = mul_sts.prod;
		mul_cmd.mplier   = '0;
		mul_cmd.acc_init = '0;
		unique case (state_q)
			ST_SQ_LD: begin
				mul_cmd.load   = 1'b1;
				mul_cmd.mcand  = PROD_W'(pos_abs);
				mul_cmd.mplier = MPLR_W'(pos_abs);
			end
			ST_A_LD: begin
				mul_cmd.load     = 1'b1;
				mul_cmd.mplier   = MPLR_W'(coef_a_q);
				mul_cmd.acc_init = PROD_W'({offset_b_q, {B_SHIFT{1'b0}}});
			end
			ST_S_LD: begin
				mul_cmd.load   = 1'b1;
				mul_cmd.mplier = MPLR_W'(scale_q);
			end
			default: begin
			end
		endcase
	end

	sqdp_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (mul_cmd),
		.sts    (mul_sts)
	);

	// configuration writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_steps_q <= TOTAL_STEPS_RST;
			x_start_q     <= X_START_RST;
			x_end_q       <= X_END_RST;
			x_inc_q       <= X_INCREMENT_RST;
			coef_a_q      <= COEF_A_RST;
			offset_b_q    <= OFFSET_B_RST;
			scale_q       <= DELAY_SCALE_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_TOTAL_STEPS: total_steps_q <= cfg_data[STEPS_W-1:0];
				REG_X_START:     x_start_q     <= $signed(cfg_data[POS_W-1:0]);
				REG_X_END:       x_end_q       <= $signed(cfg_data[POS_W-1:0]);
				REG_X_INCREMENT: x_inc_q       <= cfg_data[INC_W-1:0];
				REG_COEF_A:      coef_a_q      <= cfg_data[COEF_W-1:0];
				REG_OFFSET_B:    offset_b_q    <= cfg_data[COEF_W-1:0];
				REG_DELAY_SCALE: scale_q       <= cfg_data[SCALE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// item sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			dir_q        <= 1'b0;
			step_q       <= '0;
			pos_q        <= '0;
			half_delay_q <= '0;
			delay_left_q <= '0;
			phase_q      <= PH_IDLE;
			done_q       <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						done_q  <= 1'b0;
						state_q <= ST_EMIT;
						if (is_idle) begin
							phase_q <= PH_IDLE;
						end
						if (in_action == ACT_START) begin
							if (is_idle) begin
								dir_q  <= in_dir;
								step_q <= '0;
								pos_q  <= x_start_q;
								if (empty_move) begin
									half_delay_q <= '0;
									delay_left_q <= '0;
									done_q       <= 1'b1;
								end else begin
									state_q <= ST_SQ_LD;
								end
							end
						end else if (!is_idle) begin
							delay_left_q <= dl_dec;
							if (dl_dec == '0) begin
								if (phase_q == PH_HIGH) begin
									phase_q      <= PH_LOW;
									delay_left_q <= half_len(half_delay_q);
								end else begin
									step_q <= step_inc;
									pos_q  <= pos_sat;
									if ((step_inc >= total_steps_q)
										|| (pos_next >= (POS_W+1)'(x_end_q))) begin
										phase_q      <= PH_IDLE;
										delay_left_q <= '0;
										done_q       <= 1'b1;
									end else begin
										state_q <= ST_SQ_LD;
									end
								end
							end
						end
					end
				end
				ST_SQ_LD:  state_q <= ST_SQ_RUN;
				ST_SQ_RUN: if (!mul_sts.busy) state_q <= ST_A_LD;
				ST_A_LD:   state_q <= ST_A_RUN;
				ST_A_RUN:  if (!mul_sts.busy) state_q <= ST_S_LD;
				ST_S_LD:   state_q <= ST_S_RUN;
				ST_S_RUN: begin
					if (!mul_sts.busy) begin
						half_delay_q <= delay_sat;
						delay_left_q <= half_len(delay_sat);
						phase_q      <= PH_HIGH;
						state_q      <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					// hold until the output register is free
					if (emit_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register: advance on load, drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit_go) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			m_tdata_q <= M_DATA_W'({half_delay_q, busy_now, dir_q, phase_q == PH_HIGH});
			m_tlast_q <= done_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

endmodule

`default_nettype wire

// ===== rtl/sqdp_checker.sv =====
// ----------------------------------------------------------------------------
// sqdp_checker
// Port-level checks of the quadratic delay profile unit, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module sqdp_checker
	import sqdp_pkg::*;
(
	input wire                clk,
	input wire                arst_n,
	input wire                s_tvalid,
	input wire                s_tready,
	input wire                m_tvalid,
	input wire                m_tready,
	input wire [M_DATA_W-1:0] m_tdata,
	input wire                m_tlast
);

	// a stalled output transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output transaction changed while stalled");

	// one item at a time: no acceptance in the cycle after a transaction
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted back to back");

	// a finished move reports not busy
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> !m_tdata[2])
		else $error("move done while busy");

	// the pulse is only high inside a move
	a_pulse_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[2])
		else $error("pulse high while idle");

endmodule

bind stepper_quadratic_delay_profile_unit sqdp_checker u_sqdp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

`default_nettype wire
